/* rtl/core/lpif_pkg.sv */
// Shared types and constants of the line pair intersection filter.
package lpif_pkg;

  // Fixed field widths
  localparam int REGION_BITS = 11;
  localparam int SLOPE_BITS  = 16;
  localparam int SPREAD_BITS = 12;
  localparam int SLOPE_FRAC  = 12;
  localparam int PT_W        = 20;
  localparam int STATUS_W    = 3;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 16;

  // Saturation limits of a point coordinate
  localparam logic signed [PT_W-1:0] PT_MAX = 20'sh7FFFF;
  localparam logic signed [PT_W-1:0] PT_MIN = 20'sh80000;

  // Result status codes
  localparam logic [STATUS_W-1:0] STAT_OK       = 3'd0;
  localparam logic [STATUS_W-1:0] STAT_PARALLEL = 3'd1;
  localparam logic [STATUS_W-1:0] STAT_ANGLE    = 3'd2;
  localparam logic [STATUS_W-1:0] STAT_REGION   = 3'd3;
  localparam logic [STATUS_W-1:0] STAT_SPREAD   = 3'd4;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_X_MIN     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_X_MAX     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_Y_MIN     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_Y_MAX     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_SLOPE = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_SLOPE = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_SPREAD    = 3'd6;

  // Configuration reset values
  localparam logic [REGION_BITS-1:0] RST_X_MIN     = 11'd540;
  localparam logic [REGION_BITS-1:0] RST_X_MAX     = 11'd740;
  localparam logic [REGION_BITS-1:0] RST_Y_MIN     = 11'd400;
  localparam logic [REGION_BITS-1:0] RST_Y_MAX     = 11'd600;
  localparam logic [SLOPE_BITS-1:0]  RST_MIN_SLOPE = 16'd722;
  localparam logic [SLOPE_BITS-1:0]  RST_MAX_SLOPE = 16'd23229;
  localparam logic [SPREAD_BITS-1:0] RST_SPREAD    = 12'd1000;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_PROD,
    ST_CLASS,
    ST_NUM,
    ST_DIVSET,
    ST_DIVGO,
    ST_DIVRUN,
    ST_REGION,
    ST_SQ,
    ST_PUSH,
    ST_VAR1,
    ST_VAR2,
    ST_VAR3,
    ST_UNDO,
    ST_DONE
  } state_t;

  // Controller to datapath
  typedef struct packed {
    logic                load;
    logic                prod;
    logic                klass;
    logic                num;
    logic                divset;
    logic                divgo;
    logic                sq;
    logic                push;
    logic                var1;
    logic                var2;
    logic                undo;
    logic                res_load;
    logic [STATUS_W-1:0] res_status;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic vert;
    logic slope_bad;
    logic div_done;
    logic region_out;
    logic spread_bad;
  } stat_t;

endpackage

/* rtl/core/lpif_div.sv */
// Restoring divider, one quotient bit per cycle.
module lpif_div #(
  parameter int DW = 40,
  parameter int VW = 24
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [DW-1:0] dividend,
  input  logic [VW-1:0] divisor,
  output logic [DW-1:0] quotient,
  output logic          done
);

  localparam int CNTW = $clog2(DW + 1);

  logic            busy;
  logic [CNTW-1:0] cnt;
  logic [VW-1:0]   rem;
  logic [VW-1:0]   dvs;
  logic [DW-1:0]   quo;
  logic [VW:0]     trial;
  logic            fits;
  logic [VW-1:0]   rem_next;

  // Shift in the next dividend bit and try a subtract
  always_comb begin
    trial    = {rem, quo[DW-1]};
    fits     = trial >= {1'b0, dvs};
    rem_next = fits ? VW'(trial - {1'b0, dvs}) : VW'(trial);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNTW'(DW);
        rem  <= '0;
        quo  <= dividend;
        dvs  <= divisor;
      end else if (busy) begin
        rem <= rem_next;
        quo <= {quo[DW-2:0], fits};
        cnt <= cnt - 1'b1;
        if (cnt == CNTW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign quotient = quo;

endmodule

/* rtl/core/lpif_dpath.sv */
// Datapath: geometry products, dividers, point window and result register.
module lpif_dpath #(
  parameter int WINDOW_DEPTH  = 100,
  parameter int COORD_BITS    = 11,
  parameter int FRACTION_BITS = 4
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  lpif_pkg::cmd_t                        cmd,
  output lpif_pkg::stat_t                       stat,
  input  logic [COORD_BITS-1:0]                 a_start_x,
  input  logic [COORD_BITS-1:0]                 a_start_y,
  input  logic [COORD_BITS-1:0]                 a_end_x,
  input  logic [COORD_BITS-1:0]                 a_end_y,
  input  logic [COORD_BITS-1:0]                 b_start_x,
  input  logic [COORD_BITS-1:0]                 b_start_y,
  input  logic [COORD_BITS-1:0]                 b_end_x,
  input  logic [COORD_BITS-1:0]                 b_end_y,
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [lpif_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [lpif_pkg::CFG_DATA_W-1:0]       cfg_data,
  output logic [lpif_pkg::STATUS_W-1:0]         status,
  output logic signed [lpif_pkg::PT_W-1:0]      point_x,
  output logic signed [lpif_pkg::PT_W-1:0]      point_y,
  output logic [$clog2(WINDOW_DEPTH+1)-1:0]     window_fill
);

  localparam int C     = COORD_BITS;
  localparam int F     = FRACTION_BITS;
  localparam int D     = WINDOW_DEPTH;
  localparam int DXW   = C + 1;
  localparam int CW2   = 2 * C + 1;
  localparam int QW    = 3 * C + 2;
  localparam int NW    = 3 * C + 3;
  localparam int MAGW  = 3 * C + 1;
  localparam int DENW  = 2 * C + 1;
  localparam int DW    = 3 * C + 3 + F;
  localparam int VW    = 2 * C + 2;
  localparam int SLW   = lpif_pkg::SLOPE_BITS + C;
  localparam int PTW   = lpif_pkg::PT_W;
  localparam int EW    = lpif_pkg::REGION_BITS + F;
  localparam int CW    = $clog2(D + 1);
  localparam int HW    = $clog2(D);
  localparam int SW    = EW + CW;
  localparam int SQW   = 2 * EW + CW;
  localparam int VXW   = 2 * SW;
  localparam int LIMW  = CW + lpif_pkg::SPREAD_BITS + F;
  localparam int CMPW  = (VXW > 2 * LIMW) ? VXW : 2 * LIMW;

  // Configuration registers
  logic [lpif_pkg::REGION_BITS-1:0] rx_min, rx_max, ry_min, ry_max;
  logic [lpif_pkg::SLOPE_BITS-1:0]  min_slope, max_slope;
  logic [lpif_pkg::SPREAD_BITS-1:0] spread_limit;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      rx_min       <= lpif_pkg::RST_X_MIN;
      rx_max       <= lpif_pkg::RST_X_MAX;
      ry_min       <= lpif_pkg::RST_Y_MIN;
      ry_max       <= lpif_pkg::RST_Y_MAX;
      min_slope    <= lpif_pkg::RST_MIN_SLOPE;
      max_slope    <= lpif_pkg::RST_MAX_SLOPE;
      spread_limit <= lpif_pkg::RST_SPREAD;
    end else if (cfg_valid) begin
      case (cfg_index)
        lpif_pkg::CFG_X_MIN:     rx_min <= cfg_data[lpif_pkg::REGION_BITS-1:0];
        lpif_pkg::CFG_X_MAX:     rx_max <= cfg_data[lpif_pkg::REGION_BITS-1:0];
        lpif_pkg::CFG_Y_MIN:     ry_min <= cfg_data[lpif_pkg::REGION_BITS-1:0];
        lpif_pkg::CFG_Y_MAX:     ry_max <= cfg_data[lpif_pkg::REGION_BITS-1:0];
        lpif_pkg::CFG_MIN_SLOPE: min_slope <= cfg_data[lpif_pkg::SLOPE_BITS-1:0];
        lpif_pkg::CFG_MAX_SLOPE: max_slope <= cfg_data[lpif_pkg::SLOPE_BITS-1:0];
        lpif_pkg::CFG_SPREAD:    spread_limit <= cfg_data[lpif_pkg::SPREAD_BITS-1:0];
        default: ;
      endcase
    end
  end

  // Captured endpoints and extents
  logic [C-1:0]            x1, y1, x2, y2, x3, y3, x4, y4;
  logic signed [DXW-1:0]   dxa, dya, dxb, dyb;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      x1  <= a_start_x;
      y1  <= a_start_y;
      x2  <= a_end_x;
      y2  <= a_end_y;
      x3  <= b_start_x;
      y3  <= b_start_y;
      x4  <= b_end_x;
      y4  <= b_end_y;
      dxa <= $signed({1'b0, a_end_x}) - $signed({1'b0, a_start_x});
      dya <= $signed({1'b0, a_end_y}) - $signed({1'b0, a_start_y});
      dxb <= $signed({1'b0, b_end_x}) - $signed({1'b0, b_start_x});
      dyb <= $signed({1'b0, b_end_y}) - $signed({1'b0, b_start_y});
    end
  end

  // Magnitudes of the extents
  logic [C-1:0] axa, aya, axb, ayb;

  always_comb begin
    axa = dxa[DXW-1] ? C'(-dxa) : C'(dxa);
    aya = dya[DXW-1] ? C'(-dya) : C'(dya);
    axb = dxb[DXW-1] ? C'(-dxb) : C'(dxb);
    ayb = dyb[DXW-1] ? C'(-dyb) : C'(dyb);
  end

  // First products: cross terms, line constants, slope limits
  logic signed [2*DXW-1:0] pa, pb;
  logic [2*C-1:0]          p1, p2, p3, p4;
  logic [SLW-1:0]          lo_a, hi_a, lo_b, hi_b;
  logic [SLW-1:0]          ay_a, ay_b;

  always_ff @(posedge clk) begin
    if (cmd.prod) begin
      pa   <= dxa * dyb;
      pb   <= dya * dxb;
      p1   <= x1 * y2;
      p2   <= y1 * x2;
      p3   <= x3 * y4;
      p4   <= y3 * x4;
      lo_a <= min_slope * axa;
      hi_a <= max_slope * axa;
      lo_b <= min_slope * axb;
      hi_b <= max_slope * axb;
      ay_a <= SLW'(aya) << lpif_pkg::SLOPE_FRAC;
      ay_b <= SLW'(ayb) << lpif_pkg::SLOPE_FRAC;
    end
  end

  // Denominator and line constants
  logic signed [DENW+0:0]  den;
  logic signed [CW2-1:0]   ca, cb;

  always_ff @(posedge clk) begin
    if (cmd.klass) begin
      den <= (DENW+1)'(pa - pb);
      ca  <= $signed({1'b0, p1}) - $signed({1'b0, p2});
      cb  <= $signed({1'b0, p3}) - $signed({1'b0, p4});
    end
  end

  // Numerator products and denominator magnitude
  logic signed [QW-1:0]  q1, q2, q3, q4;
  logic [DENW-1:0]       den_mag;
  logic                  den_neg;

  always_ff @(posedge clk) begin
    if (cmd.num) begin
      q1      <= cb * dxa;
      q2      <= ca * dxb;
      q3      <= cb * dya;
      q4      <= ca * dyb;
      den_mag <= den[DENW] ? DENW'(-den) : DENW'(den);
      den_neg <= den[DENW];
    end
  end

  logic signed [NW-1:0] numx, numy;

  always_ff @(posedge clk) begin
    if (cmd.divset) begin
      numx <= NW'(q1) - NW'(q2);
      numy <= NW'(q3) - NW'(q4);
    end
  end

  // Rounded quotient: (2|num|*2^F + |den|) / (2|den|)
  logic [MAGW-1:0] magx, magy;
  logic [DW-1:0]   dend_x, dend_y, quo_x, quo_y;
  logic [VW-1:0]   dvs;
  logic            done_x, done_y;

  always_comb begin
    magx   = numx[NW-1] ? MAGW'(-numx) : MAGW'(numx);
    magy   = numy[NW-1] ? MAGW'(-numy) : MAGW'(numy);
    dend_x = (DW'(magx) << (F + 1)) + DW'(den_mag);
    dend_y = (DW'(magy) << (F + 1)) + DW'(den_mag);
    dvs    = VW'(den_mag) << 1;
  end

  lpif_div #(.DW(DW), .VW(VW)) u_div_x (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.divgo),
    .dividend (dend_x),
    .divisor  (dvs),
    .quotient (quo_x),
    .done     (done_x)
  );

  lpif_div #(.DW(DW), .VW(VW)) u_div_y (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.divgo),
    .dividend (dend_y),
    .divisor  (dvs),
    .quotient (quo_y),
    .done     (done_y)
  );

  // Apply sign and saturate when the quotients land
  logic signed [PTW-1:0] px, py, px_sat, py_sat;
  logic                  negx, negy;

  always_comb begin
    negx = numx[NW-1] ^ den_neg;
    negy = numy[NW-1] ^ den_neg;
    if (negx) begin
      px_sat = (quo_x > DW'(2 ** (PTW - 1))) ? lpif_pkg::PT_MIN : -$signed(quo_x[PTW-1:0]);
    end else begin
      px_sat = (quo_x > DW'(2 ** (PTW - 1) - 1)) ? lpif_pkg::PT_MAX : $signed(quo_x[PTW-1:0]);
    end
    if (negy) begin
      py_sat = (quo_y > DW'(2 ** (PTW - 1))) ? lpif_pkg::PT_MIN : -$signed(quo_y[PTW-1:0]);
    end else begin
      py_sat = (quo_y > DW'(2 ** (PTW - 1) - 1)) ? lpif_pkg::PT_MAX : $signed(quo_y[PTW-1:0]);
    end
  end

  always_ff @(posedge clk) begin
    if (done_x) begin
      px <= px_sat;
      py <= py_sat;
    end
  end

  // Point window storage, read at the head every cycle
  logic [EW-1:0] mem_x [D];
  logic [EW-1:0] mem_y [D];
  logic [EW-1:0] rd_x, rd_y, ux, uy;
  logic [HW-1:0] head, slot;
  logic [CW-1:0] count;
  logic          full;

  assign ux = px[EW-1:0];
  assign uy = py[EW-1:0];

  always_ff @(posedge clk) begin
    rd_x <= mem_x[head];
    rd_y <= mem_y[head];
    if (cmd.push) begin
      mem_x[head] <= ux;
      mem_y[head] <= uy;
    end
  end

  // Squares of the new and the oldest point
  logic [2*EW-1:0] sqx_new, sqy_new, sqx_old, sqy_old;

  always_ff @(posedge clk) begin
    if (cmd.sq) begin
      sqx_new <= ux * ux;
      sqy_new <= uy * uy;
      sqx_old <= rd_x * rd_x;
      sqy_old <= rd_y * rd_y;
      full    <= count == CW'(D);
    end
  end

  // Running sums, head and fill count
  logic [SW-1:0]  sum_x, sum_y;
  logic [SQW-1:0] sq_x, sq_y;

  always_ff @(posedge clk) begin
    if (rst) begin
      sum_x <= '0;
      sum_y <= '0;
      sq_x  <= '0;
      sq_y  <= '0;
      head  <= '0;
      slot  <= '0;
      count <= '0;
    end else if (cmd.push) begin
      sum_x <= sum_x + SW'(ux) - (full ? SW'(rd_x) : SW'(0));
      sum_y <= sum_y + SW'(uy) - (full ? SW'(rd_y) : SW'(0));
      sq_x  <= sq_x + SQW'(sqx_new) - (full ? SQW'(sqx_old) : SQW'(0));
      sq_y  <= sq_y + SQW'(sqy_new) - (full ? SQW'(sqy_old) : SQW'(0));
      slot  <= head;
      head  <= (head == HW'(D - 1)) ? HW'(0) : head + 1'b1;
      if (!full) begin
        count <= count + 1'b1;
      end
    end else if (cmd.undo) begin
      sum_x <= sum_x - SW'(ux);
      sum_y <= sum_y - SW'(uy);
      sq_x  <= sq_x - SQW'(sqx_new);
      sq_y  <= sq_y - SQW'(sqy_new);
      head  <= slot;
      count <= count - 1'b1;
    end
  end

  // Spread test: n*sum_sq - sum^2 against (n*limit << F)^2
  logic [VXW-1:0]    ns_x, ns_y, ss_x, ss_y, vx, vy;
  logic [LIMW-1:0]   lim;
  logic [2*LIMW-1:0] limsq;

  always_ff @(posedge clk) begin
    if (cmd.var1) begin
      ns_x <= count * sq_x;
      ns_y <= count * sq_y;
      ss_x <= sum_x * sum_x;
      ss_y <= sum_y * sum_y;
      lim  <= LIMW'(count * spread_limit) << F;
    end
    if (cmd.var2) begin
      vx    <= ns_x - ss_x;
      vy    <= ns_y - ss_y;
      limsq <= lim * lim;
    end
  end

  // Status flags for the controller
  logic signed [PTW-1:0] bx_lo, bx_hi, by_lo, by_hi;

  always_comb begin
    bx_lo = $signed(PTW'(rx_min) << F);
    bx_hi = $signed(PTW'(rx_max) << F);
    by_lo = $signed(PTW'(ry_min) << F);
    by_hi = $signed(PTW'(ry_max) << F);
    stat.vert       = (dxa == '0) || (dxb == '0) || (den == '0);
    stat.slope_bad  = !((lo_a < ay_a) && (ay_a < hi_a)) ||
                      !((lo_b < ay_b) && (ay_b < hi_b));
    stat.div_done   = done_x;
    stat.region_out = (px < bx_lo) || (px > bx_hi) || (py < by_lo) || (py > by_hi);
    stat.spread_bad = (CMPW'(vx) > CMPW'(limsq)) || (CMPW'(vy) > CMPW'(limsq));
  end

  // Result register; rejected geometry reports a zero point
  logic zero_pt;

  assign zero_pt = (cmd.res_status == lpif_pkg::STAT_PARALLEL) ||
                   (cmd.res_status == lpif_pkg::STAT_ANGLE);

  always_ff @(posedge clk) begin
    if (cmd.res_load) begin
      status      <= cmd.res_status;
      point_x     <= zero_pt ? PTW'(0) : px;
      point_y     <= zero_pt ? PTW'(0) : py;
      window_fill <= count;
    end
  end

  logic unused_done;
  assign unused_done = done_y;

endmodule

/* rtl/core/lpif_ctrl.sv */
// Controller: sequences one line pair through the datapath.
module lpif_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_stall,
  output logic            out_valid,
  input  logic            out_stall,
  input  lpif_pkg::stat_t stat,
  output lpif_pkg::cmd_t  cmd
);

  lpif_pkg::state_t state, state_next;
  logic [lpif_pkg::STATUS_W-1:0] res, res_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= lpif_pkg::ST_IDLE;
      res   <= lpif_pkg::STAT_OK;
    end else begin
      state <= state_next;
      res   <= res_next;
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    res_next   = res;
    case (state)
      lpif_pkg::ST_IDLE:   if (in_valid) state_next = lpif_pkg::ST_PROD;
      lpif_pkg::ST_PROD:   state_next = lpif_pkg::ST_CLASS;
      lpif_pkg::ST_CLASS:  state_next = lpif_pkg::ST_NUM;
      lpif_pkg::ST_NUM: begin
        if (stat.vert) begin
          res_next   = lpif_pkg::STAT_PARALLEL;
          state_next = lpif_pkg::ST_DONE;
        end else if (stat.slope_bad) begin
          res_next   = lpif_pkg::STAT_ANGLE;
          state_next = lpif_pkg::ST_DONE;
        end else begin
          state_next = lpif_pkg::ST_DIVSET;
        end
      end
      lpif_pkg::ST_DIVSET: state_next = lpif_pkg::ST_DIVGO;
      lpif_pkg::ST_DIVGO:  state_next = lpif_pkg::ST_DIVRUN;
      lpif_pkg::ST_DIVRUN: if (stat.div_done) state_next = lpif_pkg::ST_REGION;
      lpif_pkg::ST_REGION: begin
        if (stat.region_out) begin
          res_next   = lpif_pkg::STAT_REGION;
          state_next = lpif_pkg::ST_DONE;
        end else begin
          state_next = lpif_pkg::ST_SQ;
        end
      end
      lpif_pkg::ST_SQ:     state_next = lpif_pkg::ST_PUSH;
      lpif_pkg::ST_PUSH:   state_next = lpif_pkg::ST_VAR1;
      lpif_pkg::ST_VAR1:   state_next = lpif_pkg::ST_VAR2;
      lpif_pkg::ST_VAR2:   state_next = lpif_pkg::ST_VAR3;
      lpif_pkg::ST_VAR3: begin
        if (stat.spread_bad) begin
          res_next   = lpif_pkg::STAT_SPREAD;
          state_next = lpif_pkg::ST_UNDO;
        end else begin
          res_next   = lpif_pkg::STAT_OK;
          state_next = lpif_pkg::ST_DONE;
        end
      end
      lpif_pkg::ST_UNDO:   state_next = lpif_pkg::ST_DONE;
      lpif_pkg::ST_DONE:   if (!out_valid || !out_stall) state_next = lpif_pkg::ST_IDLE;
      default:             state_next = lpif_pkg::ST_IDLE;
    endcase
  end

  // Commands
  always_comb begin
    cmd            = '0;
    cmd.res_status = res;
    in_stall       = state != lpif_pkg::ST_IDLE;
    case (state)
      lpif_pkg::ST_IDLE:   cmd.load     = in_valid;
      lpif_pkg::ST_PROD:   cmd.prod     = 1'b1;
      lpif_pkg::ST_CLASS:  cmd.klass    = 1'b1;
      lpif_pkg::ST_NUM:    cmd.num      = 1'b1;
      lpif_pkg::ST_DIVSET: cmd.divset   = 1'b1;
      lpif_pkg::ST_DIVGO:  cmd.divgo    = 1'b1;
      lpif_pkg::ST_SQ:     cmd.sq       = 1'b1;
      lpif_pkg::ST_PUSH:   cmd.push     = 1'b1;
      lpif_pkg::ST_VAR1:   cmd.var1     = 1'b1;
      lpif_pkg::ST_VAR2:   cmd.var2     = 1'b1;
      lpif_pkg::ST_UNDO:   cmd.undo     = 1'b1;
      lpif_pkg::ST_DONE:   cmd.res_load = !out_valid || !out_stall;
      default: ;
    endcase
  end

  // Hold the result beat until taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.res_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.res_load |-> (!out_valid || !out_stall))
    else $error("result beat overwritten while stalled");

  a_undo_after_test: assert property (@(posedge clk) disable iff (rst)
    state == lpif_pkg::ST_UNDO |-> $past(state) == lpif_pkg::ST_VAR3 && $past(stat.spread_bad))
    else $error("window undo without a failed spread test");

  a_div_exit: assert property (@(posedge clk) disable iff (rst)
    (state == lpif_pkg::ST_DIVRUN && stat.div_done) |=> state == lpif_pkg::ST_REGION)
    else $error("divider finish not followed by region test");

endmodule

/* rtl/core/line_pair_intersection_filter.sv */
// Top level of the line pair intersection filter.
//
//   channel  direction  handshake              beat
//   in       in         in_valid / in_stall    two segments, eight endpoint coords
//   out      out        out_valid / out_stall  status, point_x, point_y, window_fill
//   cfg      in         cfg_valid / cfg_ready  cfg_index, cfg_data
//
// One line pair runs from accept to result through the controller states; the
// two restoring dividers, one quotient bit per cycle, take most of that time.
// Rejected geometry finishes before the dividers start.
// Reset is synchronous; it restores register defaults and empties the window.
// A new pair is accepted while a finished result still waits on out_stall.
module line_pair_intersection_filter #(
  parameter int WINDOW_DEPTH  = 100,
  parameter int COORD_BITS    = 11,
  parameter int FRACTION_BITS = 4
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [COORD_BITS-1:0]               a_start_x,
  input  logic [COORD_BITS-1:0]               a_start_y,
  input  logic [COORD_BITS-1:0]               a_end_x,
  input  logic [COORD_BITS-1:0]               a_end_y,
  input  logic [COORD_BITS-1:0]               b_start_x,
  input  logic [COORD_BITS-1:0]               b_start_y,
  input  logic [COORD_BITS-1:0]               b_end_x,
  input  logic [COORD_BITS-1:0]               b_end_y,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [lpif_pkg::STATUS_W-1:0]       status,
  output logic signed [lpif_pkg::PT_W-1:0]    point_x,
  output logic signed [lpif_pkg::PT_W-1:0]    point_y,
  output logic [$clog2(WINDOW_DEPTH+1)-1:0]   window_fill,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [lpif_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [lpif_pkg::CFG_DATA_W-1:0]     cfg_data
);

  lpif_pkg::cmd_t  cmd;
  lpif_pkg::stat_t stat;

  lpif_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .stat      (stat),
    .cmd       (cmd)
  );

  lpif_dpath #(
    .WINDOW_DEPTH  (WINDOW_DEPTH),
    .COORD_BITS    (COORD_BITS),
    .FRACTION_BITS (FRACTION_BITS)
  ) u_dpath (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .stat        (stat),
    .a_start_x   (a_start_x),
    .a_start_y   (a_start_y),
    .a_end_x     (a_end_x),
    .a_end_y     (a_end_y),
    .b_start_x   (b_start_x),
    .b_start_y   (b_start_y),
    .b_end_x     (b_end_x),
    .b_end_y     (b_end_y),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .status      (status),
    .point_x     (point_x),
    .point_y     (point_y),
    .window_fill (window_fill)
  );

endmodule

/* tb/line_pair_intersection_filter_tb.sv */
// Self-checking testbench for the line pair intersection filter: directed table, then random pairs.
`timescale 1ns / 1ps

module line_pair_intersection_filter_tb;
  import lpif_pkg::*;

  localparam int DEPTH   = 100;
  localparam int CB      = 11;
  localparam int FB      = 4;
  localparam int SETTLE  = 80;

  typedef struct packed {
    logic [CB-1:0] asx, asy, aex, aey, bsx, bsy, bex, bey;
  } pair_t;

  typedef struct packed {
    logic [STATUS_W-1:0]    st;
    logic signed [PT_W-1:0] px;
    logic signed [PT_W-1:0] py;
    logic [6:0]             fill;
  } point_res_t;

  typedef struct {
    pair_t      p;
    bit         lit;
    point_res_t e;
  } row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  pair_t cur = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [STATUS_W-1:0] status;
  logic signed [PT_W-1:0] point_x, point_y;
  logic [6:0] window_fill;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  line_pair_intersection_filter DUT (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .a_start_x(cur.asx), .a_start_y(cur.asy), .a_end_x(cur.aex), .a_end_y(cur.aey),
    .b_start_x(cur.bsx), .b_start_y(cur.bsy), .b_end_x(cur.bex), .b_end_y(cur.bey),
    .out_valid(out_valid), .out_stall(out_stall),
    .status(status), .point_x(point_x), .point_y(point_y), .window_fill(window_fill),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  // Mirror of the block's registers and window
  longint unsigned x_lo = RST_X_MIN, x_hi = RST_X_MAX, y_lo = RST_Y_MIN, y_hi = RST_Y_MAX;
  longint unsigned slope_lo = RST_MIN_SLOPE, slope_hi = RST_MAX_SLOPE, spread = RST_SPREAD;
  longint unsigned win_x[DEPTH], win_y[DEPTH];
  int unsigned head = 0, count = 0;
  longint unsigned sx = 0, sy = 0, sxx = 0, syy = 0;

  point_res_t pending_points[$];
  int errors = 0;
  int results_seen = 0;
  int burst_left = 4;

  task automatic report_mismatch(string what, longint got, longint want);
    $display("mismatch %s: got %0d want %0d at %0t", what, got, want, $realtime);
    errors++;
  endtask

  function automatic longint unsigned mag(longint v);
    return v < 0 ? -v : v;
  endfunction

  // Round num*2^FB/den to nearest, ties away from zero, then saturate
  function automatic longint round_div(longint num, longint den);
    longint unsigned n, d, q;
    n = mag(num) << FB;
    d = mag(den);
    q = (2 * n + d) / (2 * d);
    if ((num < 0) != (den < 0)) return (q > 524288) ? -524288 : -longint'(q);
    return (q > 524287) ? 524287 : longint'(q);
  endfunction

  function automatic bit slope_pass(longint dx, longint dy);
    longint unsigned ax, ay;
    ax = mag(dx);
    ay = mag(dy) << 12;
    return (slope_lo * ax < ay) && (ay < slope_hi * ax);
  endfunction

  function automatic point_res_t predict_point(pair_t p);
    longint x1, y1, x2, y2, x3, y3, x4, y4, dxa, dya, dxb, dyb, ca, cb, den, px, py;
    longint unsigned ux, uy, n, lim, vx, vy;
    int unsigned slot;
    point_res_t r;
    x1 = p.asx; y1 = p.asy; x2 = p.aex; y2 = p.aey;
    x3 = p.bsx; y3 = p.bsy; x4 = p.bex; y4 = p.bey;
    dxa = x2 - x1; dya = y2 - y1; dxb = x4 - x3; dyb = y4 - y3;
    px = 0; py = 0;
    if (dxa == 0 || dxb == 0 || dya * dxb == dyb * dxa) begin
      r.st = STAT_PARALLEL;
    end else if (!slope_pass(dxa, dya) || !slope_pass(dxb, dyb)) begin
      r.st = STAT_ANGLE;
    end else begin
      ca = x1 * y2 - y1 * x2;
      cb = x3 * y4 - y3 * x4;
      den = dxa * dyb - dya * dxb;
      px = round_div(cb * dxa - ca * dxb, den);
      py = round_div(cb * dya - ca * dyb, den);
      if (px < longint'(x_lo << FB) || px > longint'(x_hi << FB) ||
          py < longint'(y_lo << FB) || py > longint'(y_hi << FB)) begin
        r.st = STAT_REGION;
      end else begin
        ux = px; uy = py; slot = head;
        // evict oldest when full
        if (count >= DEPTH) begin
          sx -= win_x[slot]; sy -= win_y[slot];
          sxx -= win_x[slot] * win_x[slot]; syy -= win_y[slot] * win_y[slot];
        end else begin
          count++;
        end
        win_x[slot] = ux; win_y[slot] = uy;
        sx += ux; sy += uy; sxx += ux * ux; syy += uy * uy;
        head = (slot + 1) % DEPTH;
        n = count;
        lim = (n * spread) << FB;
        vx = n * sxx - sx * sx;
        vy = n * syy - sy * sy;
        // withdraw the new point when spread is too large
        if (vx > lim * lim || vy > lim * lim) begin
          sx -= ux; sy -= uy; sxx -= ux * ux; syy -= uy * uy;
          head = slot;
          count--;
          r.st = STAT_SPREAD;
        end else begin
          r.st = STAT_OK;
        end
      end
    end
    r.px = px[PT_W-1:0];
    r.py = py[PT_W-1:0];
    r.fill = count[6:0];
    return r;
  endfunction

  // Offer one pair, hold until accepted, then record its expected point
  task automatic offer_pair(pair_t p, bit lit, point_res_t e);
    point_res_t r;
    int gap;
    cur <= p;
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall);
    r = predict_point(p);
    pending_points.push_back(lit ? e : r);
    burst_left--;
    if (burst_left <= 0) begin
      burst_left = $urandom_range(1, 12);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 9);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  // Hold input until every expected point is back, then let the block settle
  task automatic drain_points();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_points.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    cfg_index <= idx;
    cfg_data <= val;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      CFG_X_MIN:     x_lo = val & 16'h7FF;
      CFG_X_MAX:     x_hi = val & 16'h7FF;
      CFG_Y_MIN:     y_lo = val & 16'h7FF;
      CFG_Y_MAX:     y_hi = val & 16'h7FF;
      CFG_MIN_SLOPE: slope_lo = val;
      CFG_MAX_SLOPE: slope_hi = val;
      CFG_SPREAD:    spread = val & 16'hFFF;
      default: ;
    endcase
  endtask

  function automatic logic [CB-1:0] clamp_coord(longint v);
    return (v < 0) ? '0 : (v > 2047) ? 11'd2047 : v[CB-1:0];
  endfunction

  function automatic longint pick_in(longint lo, longint hi);
    if (lo > hi) return $urandom_range(0, 2047);
    return $urandom_range(hi, lo);
  endfunction

  // Segment through c with a slope drawn from the configured angle range
  function automatic void line_through(longint cx, longint cy, output logic [CB-1:0] sx0,
      output logic [CB-1:0] sy0, output logic [CB-1:0] ex0, output logic [CB-1:0] ey0);
    longint dx, dy, r, lo, hi;
    dx = $urandom_range(4, 150);
    lo = slope_lo + 1;
    hi = (slope_hi > 0) ? slope_hi - 1 : 0;
    if (hi > 40000) hi = 40000;
    if (lo > hi) r = $urandom_range(0, 40000);
    else r = $urandom_range(hi, lo);
    dy = (dx * r) >> 12;
    if ($urandom_range(0, 1)) dy = -dy;
    sx0 = clamp_coord(cx - dx); sy0 = clamp_coord(cy - dy);
    ex0 = clamp_coord(cx + dx + $urandom_range(0, 1)); ey0 = clamp_coord(cy + dy);
  endfunction

  function automatic pair_t make_pair();
    pair_t p;
    longint cx, cy;
    int kind;
    kind = $urandom_range(0, 99);
    p = {$urandom, $urandom, $urandom};
    if (kind < 75) begin
      // well-formed crossing inside the region
      cx = pick_in(x_lo, x_hi);
      cy = pick_in(y_lo, y_hi);
      line_through(cx, cy, p.asx, p.asy, p.aex, p.aey);
      line_through(cx, cy, p.bsx, p.bsy, p.bex, p.bey);
    end else if (kind < 82) begin
      p.aex = p.asx;
    end else if (kind < 87) begin
      // parallel copy shifted sideways
      p.bsx = p.asx ^ 11'd1; p.bex = p.aex ^ 11'd1;
      p.bsy = p.asy ^ 11'd1; p.bey = p.aey ^ 11'd1;
      if (p.bsx - p.asx != p.bex - p.aex || p.bsy - p.asy != p.bey - p.aey) p.bsx = p.bex;
    end else if (kind < 90) begin
      p.bey = p.bsy;
    end
    return p;
  endfunction

  task automatic random_phase(int items);
    point_res_t none;
    none = '0;
    repeat (items) offer_pair(make_pair(), 1'b0, none);
  endtask

  // Directed rows; literal expectations where the answer is plain
  row_t rows[$];
  function automatic row_t mk(pair_t p, bit lit, logic [2:0] st, int px, int py, int fill);
    row_t r;
    r.p = p; r.lit = lit;
    r.e.st = st; r.e.px = px; r.e.py = py; r.e.fill = fill;
    return r;
  endfunction

  initial begin
    rows.push_back(mk('0, 1, STAT_PARALLEL, 0, 0, 0));
    rows.push_back(mk('1, 1, STAT_PARALLEL, 0, 0, 0));
    rows.push_back(mk({11'd100, 11'd0, 11'd100, 11'd500, 11'd0, 11'd0, 11'd90, 11'd300},
                      1, STAT_PARALLEL, 0, 0, 0));
    rows.push_back(mk({11'd0, 11'd0, 11'd100, 11'd200, 11'd10, 11'd0, 11'd110, 11'd200},
                      1, STAT_PARALLEL, 0, 0, 0));
    rows.push_back(mk({11'd0, 11'd10, 11'd500, 11'd10, 11'd0, 11'd0, 11'd100, 11'd300},
                      1, STAT_ANGLE, 0, 0, 0));
    rows.push_back(mk({11'd0, 11'd0, 11'd100, 11'd300, 11'd0, 11'd0, 11'd1, 11'd2047},
                      1, STAT_ANGLE, 0, 0, 0));
    rows.push_back(mk({11'd540, 11'd400, 11'd740, 11'd600, 11'd540, 11'd600, 11'd740, 11'd400},
                      1, STAT_OK, 10240, 8000, 1));
    rows.push_back(mk({11'd540, 11'd400, 11'd740, 11'd600, 11'd540, 11'd600, 11'd740, 11'd400},
                      1, STAT_OK, 10240, 8000, 2));
    rows.push_back(mk({11'd0, 11'd0, 11'd200, 11'd200, 11'd0, 11'd200, 11'd200, 11'd0},
                      1, STAT_REGION, 1600, 1600, 2));
    rows.push_back(mk({11'd440, 11'd300, 11'd640, 11'd500, 11'd440, 11'd500, 11'd640, 11'd300},
                      1, STAT_OK, 8640, 6400, 3));
    rows.push_back(mk({11'd439, 11'd300, 11'd639, 11'd500, 11'd439, 11'd500, 11'd639, 11'd300},
                      1, STAT_REGION, 8624, 6400, 3));
    rows.push_back(mk({11'd10, 11'd0, 11'd20, 11'd50, 11'd30, 11'd0, 11'd40, 11'd40},
                      0, 0, 0, 0, 0));
    rows.push_back(mk({11'd0, 11'd0, 11'd400, 11'd2000, 11'd1, 11'd0, 11'd401, 11'd2001},
                      0, 0, 0, 0, 0));
    rows.push_back(mk({11'd2047, 11'd0, 11'd0, 11'd2047, 11'd0, 11'd0, 11'd2047, 11'd2047},
                      0, 0, 0, 0, 0));
    rows.push_back(mk({11'd541, 11'd401, 11'd700, 11'd599, 11'd545, 11'd590, 11'd731, 11'd410},
                      0, 0, 0, 0, 0));
    rows.push_back(mk({11'd600, 11'd450, 11'd601, 11'd452, 11'd600, 11'd453, 11'd603, 11'd448},
                      0, 0, 0, 0, 0));
    rows.push_back(mk({11'd1024, 11'd1023, 11'd2046, 11'd1, 11'd1, 11'd2046, 11'd1023, 11'd1024},
                      0, 0, 0, 0, 0));

    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (rows[i]) offer_pair(rows[i].p, rows[i].lit, rows[i].e);
    random_phase(400);

    // widest settings: full region, open angles, largest spread
    drain_points();
    write_reg(CFG_X_MIN, 16'd0);
    write_reg(CFG_X_MAX, 16'hFFFF);
    write_reg(CFG_Y_MIN, 16'd0);
    write_reg(CFG_Y_MAX, 16'd2047);
    write_reg(CFG_MIN_SLOPE, 16'd0);
    write_reg(CFG_MAX_SLOPE, 16'hFFFF);
    write_reg(CFG_SPREAD, 16'hFFFF);
    random_phase(350);

    // tight spread so points get withdrawn
    drain_points();
    write_reg(CFG_X_MIN, 16'd540);
    write_reg(CFG_X_MAX, 16'd740);
    write_reg(CFG_Y_MIN, 16'd400);
    write_reg(CFG_Y_MAX, 16'd600);
    write_reg(CFG_MIN_SLOPE, 16'd722);
    write_reg(CFG_MAX_SLOPE, 16'd23229);
    write_reg(CFG_SPREAD, 16'd2);
    random_phase(300);

    // single-pixel region, zero spread; index past the list is ignored
    drain_points();
    write_reg(CFG_X_MIN, 16'd640);
    write_reg(CFG_X_MAX, 16'd640);
    write_reg(CFG_Y_MIN, 16'd500);
    write_reg(CFG_Y_MAX, 16'd500);
    write_reg(CFG_SPREAD, 16'd0);
    write_reg(3'd7, 16'hFFFF);
    random_phase(200);

    // narrow angle band, mid spread
    drain_points();
    write_reg(CFG_X_MIN, 16'd300);
    write_reg(CFG_X_MAX, 16'd1500);
    write_reg(CFG_Y_MIN, 16'd300);
    write_reg(CFG_Y_MAX, 16'd1500);
    write_reg(CFG_MIN_SLOPE, 16'd4096);
    write_reg(CFG_MAX_SLOPE, 16'd8192);
    write_reg(CFG_SPREAD, 16'd50);
    random_phase(300);

    drain_points();
    if (errors == 0) begin
      $display("line_pair_intersection_filter_tb: clean");
    end else begin
      $display("line_pair_intersection_filter_tb: errors");
    end
    $finish;
  end

  // Check each output beat; stall on shifting patterns with one long hold
  int stall_mode = 0;
  int mode_left = 0;
  int hold_left = 0;
  bit hold_done = 1'b0;
  point_res_t want;

  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        results_seen++;
        if (pending_points.size() == 0) begin
          report_mismatch("unexpected beat, status", status, -1);
        end else begin
          want = pending_points.pop_front();
          if (status !== want.st) report_mismatch("status", status, want.st);
          if (point_x !== want.px) report_mismatch("point_x", point_x, want.px);
          if (point_y !== want.py) report_mismatch("point_y", point_y, want.py);
          if (window_fill !== want.fill) report_mismatch("window_fill", window_fill, want.fill);
        end
      end
      if (!hold_done && results_seen == 250) begin
        hold_done <= 1'b1;
        hold_left <= 600;
        out_stall <= 1'b1;
      end else if (hold_left > 0) begin
        hold_left <= hold_left - 1;
        out_stall <= (hold_left > 1);
      end else begin
        if (mode_left == 0) begin
          stall_mode <= $urandom_range(0, 3);
          mode_left <= $urandom_range(20, 120);
        end else begin
          mode_left <= mode_left - 1;
        end
        case (stall_mode)
          0: out_stall <= 1'b0;
          1: out_stall <= ($urandom_range(0, 3) == 0);
          2: out_stall <= ($urandom_range(0, 9) < 7);
          default: out_stall <= (mode_left % 5 < 2);
        endcase
      end
    end
  end

  initial begin
    #30ms;
    $display("line_pair_intersection_filter_tb: errors");
    $finish;
  end

endmodule
